// ----- sv/tppu_pkg.sv -----
// shared types, pipeline stage numbers and fixed-point helpers of the projection unit
`default_nettype none

package tppu_pkg;

    localparam int UNIT_BITS = 30;
    localparam logic [31:0] REF_SWITCH = 32'd966367642;

    localparam int SQRT_LAT  = 32;
    localparam int DIV_STEPS = 31;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    // register stage of each step, counted from the input register
    localparam int ST_SUM   = 1;
    localparam int ST_ROOT1 = ST_SUM + SQRT_LAT;
    localparam int ST_N     = ST_ROOT1 + DIV_LAT;
    localparam int ST_REF   = ST_N + 1;
    localparam int ST_PROD  = ST_REF + 1;
    localparam int ST_UP    = ST_PROD + 1;
    localparam int ST_USQ   = ST_UP + 1;
    localparam int ST_USUM  = ST_USQ + 1;
    localparam int ST_ROOT2 = ST_USUM + SQRT_LAT;
    localparam int ST_U     = ST_ROOT2 + DIV_LAT;
    localparam int ST_VP    = ST_U + 1;
    localparam int ST_VD    = ST_VP + 1;
    localparam int ST_V     = ST_VD + 1;
    localparam int ST_OUT   = ST_V + 3;

    typedef logic signed [31:0] word_t;
    typedef logic signed [32:0] vwide_t;
    typedef logic signed [66:0] acc_t;

    typedef struct packed {
        word_t normal_x;
        word_t normal_y;
        word_t normal_z;
        word_t vertex0_x;
        word_t vertex0_y;
        word_t vertex0_z;
        word_t vertex1_x;
        word_t vertex1_y;
        word_t vertex1_z;
        word_t vertex2_x;
        word_t vertex2_y;
        word_t vertex2_z;
    } in_item_t;

    typedef struct packed {
        word_t vertex0_u;
        word_t vertex0_v;
        word_t vertex1_u;
        word_t vertex1_v;
        word_t vertex2_u;
        word_t vertex2_v;
        logic  degenerate;
    } out_item_t;

    // round to nearest by 2^30, halves toward plus infinity
    function automatic acc_t shr_round30(input acc_t p);
        acc_t t;
        t = p + (acc_t'(1) <<< (UNIT_BITS - 1));
        return t >>> UNIT_BITS;
    endfunction

    function automatic word_t sat32(input acc_t x);
        word_t r;
        if (x > acc_t'(64'sd2147483647))
            r = 32'sh7fffffff;
        else if (x < acc_t'(-64'sd2147483648))
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/tppu_in_if.sv -----
// input channel carrying one triangle and its face normal
`default_nettype none

interface tppu_in_if import tppu_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/tppu_out_if.sv -----
// output channel carrying the projected vertex coordinates
`default_nettype none

interface tppu_out_if import tppu_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/tppu_isqrt.sv -----
// pipelined 64-bit integer square root, one result bit per stage
`default_nettype none

module tppu_isqrt import tppu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] x,
    output logic      [31:0] root
);

    logic [35:0] rem_reg  [SQRT_LAT];
    logic [31:0] root_reg [SQRT_LAT];
    logic [63:0] xs_reg   [SQRT_LAT];
    logic [35:0] rem_next  [SQRT_LAT];
    logic [31:0] root_next [SQRT_LAT];
    logic [63:0] xs_next   [SQRT_LAT];

    always_comb
    begin
        logic [35:0] prem;
        logic [31:0] proot;
        logic [63:0] pxs;
        logic [35:0] t;
        logic [35:0] trial;
        for (int k = 0; k < SQRT_LAT; k++)
        begin
            if (k == 0)
            begin
                prem  = '0;
                proot = '0;
                pxs   = x;
            end
            else
            begin
                prem  = rem_reg[k-1];
                proot = root_reg[k-1];
                pxs   = xs_reg[k-1];
            end
            // bring down the next pair of radicand bits
            t     = {prem[33:0], pxs[63:62]};
            trial = {2'b00, proot, 2'b01};
            if (t >= trial)
            begin
                rem_next[k]  = t - trial;
                root_next[k] = {proot[30:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = t;
                root_next[k] = {proot[30:0], 1'b0};
            end
            xs_next[k] = {pxs[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_LAT; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                xs_reg[k]   <= xs_next[k];
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

`default_nettype wire

// ----- sv/tppu_div.sv -----
// pipelined rounding divider: round(x * 2^30 / den), one quotient bit per stage
`default_nettype none

module tppu_div import tppu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire word_t       x,
    input  wire logic [31:0] den,
    output word_t            q
);

    logic        neg_reg [DIV_STEPS+1];
    logic [31:0] den_reg [DIV_STEPS+1];
    logic [31:0] rem_reg [DIV_STEPS+1];
    logic [30:0] low_reg [DIV_STEPS+1];
    logic [30:0] quo_reg [DIV_STEPS+1];
    word_t       q_reg;

    logic [31:0] mag;
    logic [62:0] num;
    logic [31:0] rem_next [DIV_STEPS+1];
    logic [30:0] quo_next [DIV_STEPS+1];

    // magnitude times 2^30 plus half the divisor; quotient stays below 2^31
    assign mag = x[31] ? 32'(-x) : 32'(x);
    assign num = {1'b0, mag, 30'b0} + 63'(den >> 1);

    always_comb
    begin
        logic [32:0] t;
        rem_next[0] = num[62:31];
        quo_next[0] = '0;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            t = {rem_reg[k-1], low_reg[k-1][30]};
            if (t >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = 32'(t - {1'b0, den_reg[k-1]});
                quo_next[k] = {quo_reg[k-1][29:0], 1'b1};
            end
            else
            begin
                rem_next[k] = t[31:0];
                quo_next[k] = {quo_reg[k-1][29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= x[31];
            den_reg[0] <= den;
            rem_reg[0] <= rem_next[0];
            low_reg[0] <= num[30:0];
            quo_reg[0] <= quo_next[0];
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= {low_reg[k-1][29:0], 1'b0};
                quo_reg[k] <= quo_next[k];
            end
            q_reg <= neg_reg[DIV_STEPS] ? -word_t'({1'b0, quo_reg[DIV_STEPS]})
                                        : word_t'({1'b0, quo_reg[DIV_STEPS]});
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ----- sv/tppu_project.sv -----
// final stages: dot products of the vertices with u and v, rounding and saturation
`default_nettype none

module tppu_project import tppu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire word_t  pos [3][3],
    input  wire word_t  u [3],
    input  wire vwide_t v [3],
    input  wire logic   deg,
    output out_item_t   result
);

    logic signed [64:0] pu_reg [3][3];
    logic signed [64:0] pv_reg [3][3];
    acc_t               su_reg [3];
    acc_t               sv_reg [3];
    logic               deg1_reg;
    logic               deg2_reg;
    out_item_t          res_reg;

    logic signed [64:0] pu_next [3][3];
    logic signed [64:0] pv_next [3][3];
    acc_t               su_next [3];
    acc_t               sv_next [3];
    word_t              cu [3];
    word_t              cv [3];
    out_item_t          res_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pu_next[k][j] = 65'(pos[k][j]) * 65'(u[j]);
                pv_next[k][j] = 65'(pos[k][j]) * 65'(v[j]);
            end
            su_next[k] = acc_t'(pu_reg[k][0]) + acc_t'(pu_reg[k][1]) + acc_t'(pu_reg[k][2]);
            sv_next[k] = acc_t'(pv_reg[k][0]) + acc_t'(pv_reg[k][1]) + acc_t'(pv_reg[k][2]);
            cu[k] = deg2_reg ? word_t'(0) : sat32(shr_round30(su_reg[k]));
            cv[k] = deg2_reg ? word_t'(0) : sat32(shr_round30(sv_reg[k]));
        end
        res_next.vertex0_u  = cu[0];
        res_next.vertex0_v  = cv[0];
        res_next.vertex1_u  = cu[1];
        res_next.vertex1_v  = cv[1];
        res_next.vertex2_u  = cu[2];
        res_next.vertex2_v  = cv[2];
        res_next.degenerate = deg2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg   <= pu_next;
            pv_reg   <= pv_next;
            su_reg   <= su_next;
            sv_reg   <= sv_next;
            deg1_reg <= deg;
            deg2_reg <= deg1_reg;
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// ----- sv/triangle_plane_projection_unit.sv -----
// top level: projects a triangle's vertices onto an in-plane basis of its face normal
//
// triangle is a valid/ready sink carrying the normal and three vertices in Q16.16;
// projection is a valid/ready source carrying (u, v) of each vertex and a degenerate
// flag. A transfer happens on a rising edge with valid and ready both high.
// One triangle is taken every cycle unless the output stalls. The pipeline is the
// chain: squares, a 32-stage square root, three 33-stage rounding dividers for n,
// the Gram-Schmidt step, a second root and divider pair for u, the cross product
// for v and the dot products.
// A zero-length normal or basis gives degenerate = 1 with all coordinates zero.
// Reset clears every stage valid bit; nothing else needs clearing.
// While a finished result waits at the output, the whole pipeline holds and
// triangle.ready is low; bubbles in the pipeline are not filled while it holds.
`default_nettype none

module triangle_plane_projection_unit import tppu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tppu_in_if.sink     triangle,
    tppu_out_if.source  projection
);

    logic [ST_OUT:0] vld_reg;
    logic            en;

    word_t              nr_reg   [0:ST_ROOT1][3];
    word_t              pos_reg  [0:ST_V][3][3];
    logic [63:0]        sq_reg   [3];
    logic [63:0]        sum_reg;
    logic               deg_reg  [ST_ROOT1+1:ST_V];
    word_t              n_reg    [ST_REF:ST_U][3];
    word_t              d_reg;
    logic               refy_reg [ST_REF:ST_PROD];
    logic signed [63:0] prod_reg [3];
    word_t              up_reg   [ST_UP:ST_ROOT2][3];
    logic [63:0]        usq_reg  [3];
    logic [63:0]        usum_reg;
    word_t              u_reg    [ST_VP:ST_V][3];
    logic signed [63:0] vp_reg   [6];
    logic signed [63:0] vd_reg   [3];
    vwide_t             v_reg    [3];

    word_t              nr_in    [3];
    word_t              pos_in   [3][3];
    logic signed [63:0] sq_next  [3];
    logic [31:0]        root1;
    logic [31:0]        root2;
    word_t              n_div    [3];
    word_t              u_div    [3];
    logic [32:0]        n0_mag;
    logic signed [63:0] prod_next [3];
    word_t              up_next   [3];
    logic signed [63:0] usq_next  [3];
    logic signed [63:0] vp_next   [6];
    acc_t               v_next    [3];
    out_item_t          result;

    // the pipeline moves unless a finished result is held at the output
    assign en = !vld_reg[ST_OUT] || projection.ready;
    assign triangle.ready = en;

    assign nr_in[0] = triangle.data.normal_x;
    assign nr_in[1] = triangle.data.normal_y;
    assign nr_in[2] = triangle.data.normal_z;
    assign pos_in[0][0] = triangle.data.vertex0_x;
    assign pos_in[0][1] = triangle.data.vertex0_y;
    assign pos_in[0][2] = triangle.data.vertex0_z;
    assign pos_in[1][0] = triangle.data.vertex1_x;
    assign pos_in[1][1] = triangle.data.vertex1_y;
    assign pos_in[1][2] = triangle.data.vertex1_z;
    assign pos_in[2][0] = triangle.data.vertex2_x;
    assign pos_in[2][1] = triangle.data.vertex2_y;
    assign pos_in[2][2] = triangle.data.vertex2_z;

    tppu_isqrt u_root1 (.clk(clk), .en(en), .x(sum_reg), .root(root1));
    tppu_isqrt u_root2 (.clk(clk), .en(en), .x(usum_reg), .root(root2));

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        tppu_div u_ndiv (.clk(clk), .en(en), .x(nr_reg[ST_ROOT1][i]), .den(root1),
                         .q(n_div[i]));
        tppu_div u_udiv (.clk(clk), .en(en), .x(up_reg[ST_ROOT2][i]), .den(root2),
                         .q(u_div[i]));
    end

    assign n0_mag = n_div[0][31] ? 33'(-33'(n_div[0])) : 33'(n_div[0]);

    always_comb
    begin
        acc_t e;
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i]   = 64'(nr_in[i]) * 64'(nr_in[i]);
            prod_next[i] = 64'(d_reg) * 64'(n_reg[ST_REF][i]);
            // reference axis component minus its projection on n
            if ((i == 0 && !refy_reg[ST_PROD]) || (i == 1 && refy_reg[ST_PROD]))
                e = acc_t'(1) <<< UNIT_BITS;
            else
                e = '0;
            up_next[i]  = 32'(e - shr_round30(acc_t'(prod_reg[i])));
            usq_next[i] = 64'(up_reg[ST_UP][i]) * 64'(up_reg[ST_UP][i]);
        end
        // cross product n x u
        vp_next[0] = 64'(n_reg[ST_U][1]) * 64'(u_div[2]);
        vp_next[1] = 64'(n_reg[ST_U][2]) * 64'(u_div[1]);
        vp_next[2] = 64'(n_reg[ST_U][2]) * 64'(u_div[0]);
        vp_next[3] = 64'(n_reg[ST_U][0]) * 64'(u_div[2]);
        vp_next[4] = 64'(n_reg[ST_U][0]) * 64'(u_div[1]);
        vp_next[5] = 64'(n_reg[ST_U][1]) * 64'(u_div[0]);
        for (int i = 0; i < 3; i++)
            v_next[i] = shr_round30(acc_t'(vd_reg[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[ST_OUT-1:0], triangle.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nr_reg[0]  <= nr_in;
            pos_reg[0] <= pos_in;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= sq_next[i];
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            for (int k = 1; k <= ST_ROOT1; k++)
                nr_reg[k] <= nr_reg[k-1];
            for (int k = 1; k <= ST_V; k++)
                pos_reg[k] <= pos_reg[k-1];

            deg_reg[ST_ROOT1+1] <= (root1 == '0);
            for (int k = ST_ROOT1 + 2; k <= ST_V; k++)
            begin
                if (k == ST_ROOT2 + 1)
                    deg_reg[k] <= deg_reg[k-1] || (root2 == '0);
                else
                    deg_reg[k] <= deg_reg[k-1];
            end

            n_reg[ST_REF] <= n_div;
            for (int k = ST_REF + 1; k <= ST_U; k++)
                n_reg[k] <= n_reg[k-1];

            // y axis as reference once |n.x| reaches 0.9
            if (n0_mag < 33'(REF_SWITCH))
            begin
                d_reg            <= n_div[0];
                refy_reg[ST_REF] <= 1'b0;
            end
            else
            begin
                d_reg            <= n_div[1];
                refy_reg[ST_REF] <= 1'b1;
            end
            refy_reg[ST_PROD] <= refy_reg[ST_REF];

            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i]      <= prod_next[i];
                up_reg[ST_UP][i] <= up_next[i];
                usq_reg[i]       <= usq_next[i];
            end
            for (int k = ST_UP + 1; k <= ST_ROOT2; k++)
                up_reg[k] <= up_reg[k-1];
            usum_reg <= usq_reg[0] + usq_reg[1] + usq_reg[2];

            u_reg[ST_VP] <= u_div;
            for (int k = ST_VP + 1; k <= ST_V; k++)
                u_reg[k] <= u_reg[k-1];
            vp_reg    <= vp_next;
            vd_reg[0] <= vp_reg[0] - vp_reg[1];
            vd_reg[1] <= vp_reg[2] - vp_reg[3];
            vd_reg[2] <= vp_reg[4] - vp_reg[5];
            for (int i = 0; i < 3; i++)
                v_reg[i] <= v_next[i][32:0];
        end
    end

    tppu_project u_project (
        .clk    (clk),
        .en     (en),
        .pos    (pos_reg[ST_V]),
        .u      (u_reg[ST_V]),
        .v      (v_reg),
        .deg    (deg_reg[ST_V]),
        .result (result)
    );

    assign projection.valid = vld_reg[ST_OUT];
    assign projection.data  = result;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        projection.valid && !projection.ready |-> !triangle.ready)
        else $error("input taken while the output is stalled");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        triangle.valid && triangle.ready |=> vld_reg[0])
        else $error("accepted triangle missing from the first stage");

    a_stall_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> vld_reg == $past(vld_reg))
        else $error("stage valid bits moved during a stall");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        projection.valid && projection.data.degenerate |->
            projection.data.vertex0_u == 0 && projection.data.vertex0_v == 0 &&
            projection.data.vertex1_u == 0 && projection.data.vertex1_v == 0 &&
            projection.data.vertex2_u == 0 && projection.data.vertex2_v == 0)
        else $error("degenerate result with non-zero coordinates");

endmodule

`default_nettype wire
